// ===== design/kruskal_union_find_edge_filter_unit_defines.svh =====
// Assertion macros shared by the edge filter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef KRUSKAL_UNION_FIND_EDGE_FILTER_UNIT_DEFINES_SVH
`define KRUSKAL_UNION_FIND_EDGE_FILTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// invariant that must hold at every edge out of reset
`define KUFE_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("kufe: invariant violated");
// same-cycle implication
`define KUFE_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kufe: implication violated");
`else
`define KUFE_ASSERT_ALWAYS(lbl, expr)
`define KUFE_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// ===== design/kufe_pkg.sv =====
// Package for the Kruskal union-find edge filter: field widths, codes,
// register map and request/result payload types. No dependencies.
`default_nettype none

package kufe_pkg;

    // field widths
    localparam int NODE_W       = 10;
    localparam int WEIGHT_W     = 20;
    localparam int TOTAL_W      = 30;
    localparam int COUNT_W      = 10;
    localparam int NODE_COUNT_W = 11;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;
    localparam int MIN_NODES         = 2;
    localparam int MAX_NODES_DEFAULT = 1024;

    // operation codes
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [NODE_W-1:0]   src_node;
        logic [NODE_W-1:0]   dst_node;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_in;

    typedef struct packed {
        logic               joined;
        logic [TOTAL_W-1:0] total_weight;
        logic [COUNT_W-1:0] tree_edges;
        logic               tree_complete;
    } t_out;

endpackage

`default_nettype wire

// ===== design/kufe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the parent links of the forest.
`default_nettype none

module kufe_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/kufe_cfg.sv =====
// APB-style register block holding node_count and its clamped value.
// Depends on kufe_pkg.
`default_nettype none

module kufe_cfg #(
    parameter int MAX_NODES = kufe_pkg::MAX_NODES_DEFAULT,
    parameter int NCW       = kufe_pkg::NODE_COUNT_W
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [kufe_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [kufe_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [kufe_pkg::APB_DATA_W-1:0] prdata,
    output logic      [NCW-1:0]                  o_eff_nodes
);

    logic [kufe_pkg::NODE_COUNT_W-1:0] r_node_count;
    logic [kufe_pkg::REG_IDX_W-1:0]    reg_idx;
    logic [NCW-1:0]                    nc_ext;

    assign reg_idx = paddr[kufe_pkg::APB_ADDR_W-1:2];

    // register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= kufe_pkg::NODE_COUNT_RESET;
        end else if (psel && penable && pwrite && (reg_idx == kufe_pkg::REG_NODE_COUNT)) begin
            r_node_count <= pwdata[kufe_pkg::NODE_COUNT_W-1:0];
        end
    end

    // readback
    always_comb begin
        prdata = '0;
        if (reg_idx == kufe_pkg::REG_NODE_COUNT) begin
            prdata = kufe_pkg::APB_DATA_W'(r_node_count);
        end
    end

    // clamp to the supported vertex range
    assign nc_ext = NCW'(r_node_count);
    always_comb begin
        o_eff_nodes = nc_ext;
        if (nc_ext < NCW'(kufe_pkg::MIN_NODES)) begin
            o_eff_nodes = NCW'(kufe_pkg::MIN_NODES);
        end else if (nc_ext > NCW'(MAX_NODES)) begin
            o_eff_nodes = NCW'(MAX_NODES);
        end
    end

endmodule

`default_nettype wire

// ===== design/kruskal_union_find_edge_filter_unit.sv =====
// Kruskal edge filter: one request is a clear or an edge offered in ascending
// weight order; every request gives one result. After reset, and on every
// clear request, the parent RAM is rewritten one entry per cycle. An edge
// walks the parent links of each endpoint through the single read port of
// the parent RAM, one link per cycle, from source and then destination to
// their roots. An edge out of range, or offered once the tree is complete,
// skips the walk. The block takes no request while it clears or walks, nor
// until the result of the current request is loaded into the output
// register. A result may wait in the output register while the block
// finishes the next request.
// Depends on kufe_pkg, kufe_cfg, kufe_ram and the defines header.
`default_nettype none
`include "kruskal_union_find_edge_filter_unit_defines.svh"

module kruskal_union_find_edge_filter_unit #(
    parameter int MAX_NODES = kufe_pkg::MAX_NODES_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire kufe_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output kufe_pkg::t_out                       o_out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [kufe_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [kufe_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [kufe_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = ($clog2(MAX_NODES + 1) > kufe_pkg::NODE_COUNT_W) ?
                         $clog2(MAX_NODES + 1) : kufe_pkg::NODE_COUNT_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CLEAR  = 5'b00010,
        ST_FIND_S = 5'b00100,
        ST_FIND_D = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [NW-1:0]                r_clr_idx, n_clr_idx;
    logic                         r_report, n_report;
    logic [NW-1:0]                r_cur, n_cur;
    logic [NW-1:0]                r_root_s, n_root_s;
    logic [NW-1:0]                r_d, n_d;
    logic [kufe_pkg::WEIGHT_W-1:0] r_w, n_w;
    logic [kufe_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [kufe_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic                         r_joined, n_joined;
    logic                         r_out_valid;
    kufe_pkg::t_out               r_out;

    logic [NCW-1:0] eff_nodes;
    logic [NCW-1:0] last_edge;
    logic           in_acc;
    logic           out_load;
    logic           edge_ok;
    logic           is_root;

    logic          ram_we, ram_re;
    logic [NW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

    assign pready = 1'b1;

    kufe_cfg #(
        .MAX_NODES (MAX_NODES),
        .NCW       (NCW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .o_eff_nodes (eff_nodes)
    );

    kufe_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_NODES)
    ) u_parent (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign last_edge  = eff_nodes - NCW'(1);
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // endpoints in range and tree not yet complete
    assign edge_ok = (NCW'(i_in_data.src_node) < eff_nodes) &&
                     (NCW'(i_in_data.dst_node) < eff_nodes) &&
                     (NCW'(r_cnt) < last_edge);

    // the shared compare: a node is a root when it is its own parent
    assign is_root = (ram_rdata == r_cur);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_report  = r_report;
        n_cur     = r_cur;
        n_root_s  = r_root_s;
        n_d       = r_d;
        n_w       = r_w;
        n_total   = r_total;
        n_cnt     = r_cnt;
        n_joined  = r_joined;
        ram_we    = 1'b0;
        ram_waddr = r_cur;
        ram_wdata = r_root_s;
        ram_re    = 1'b0;
        ram_raddr = r_cur;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_joined = 1'b0;
                    if (i_in_data.operation == kufe_pkg::OP_CLEAR) begin
                        n_total   = '0;
                        n_cnt     = '0;
                        n_clr_idx = '0;
                        n_report  = 1'b1;
                        n_state   = ST_CLEAR;
                    end else begin
                        n_w = i_in_data.edge_weight;
                        n_d = NW'(i_in_data.dst_node);
                        if (edge_ok) begin
                            ram_re    = 1'b1;
                            ram_raddr = NW'(i_in_data.src_node);
                            n_cur     = NW'(i_in_data.src_node);
                            n_state   = ST_FIND_S;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_CLEAR: begin
                // every vertex becomes its own root
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = r_clr_idx;
                n_clr_idx = r_clr_idx + NW'(1);
                if (r_clr_idx == NW'(MAX_NODES - 1)) begin
                    n_state = r_report ? ST_DONE : ST_IDLE;
                end
            end
            ST_FIND_S: begin
                ram_re = 1'b1;
                if (is_root) begin
                    n_root_s  = r_cur;
                    n_cur     = r_d;
                    ram_raddr = r_d;
                    n_state   = ST_FIND_D;
                end else begin
                    n_cur     = ram_rdata;
                    ram_raddr = ram_rdata;
                end
            end
            ST_FIND_D: begin
                if (is_root) begin
                    // link the destination root under the source root
                    if (r_root_s != r_cur) begin
                        ram_we   = 1'b1;
                        n_total  = r_total + kufe_pkg::TOTAL_W'(r_w);
                        n_cnt    = r_cnt + kufe_pkg::COUNT_W'(1);
                        n_joined = 1'b1;
                    end
                    n_state = ST_DONE;
                end else begin
                    ram_re    = 1'b1;
                    n_cur     = ram_rdata;
                    ram_raddr = ram_rdata;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_report  <= 1'b0;
            r_total   <= '0;
            r_cnt     <= '0;
            r_joined  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_report  <= n_report;
            r_total   <= n_total;
            r_cnt     <= n_cnt;
            r_joined  <= n_joined;
        end
    end

    // walk payload
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_root_s <= n_root_s;
        r_d      <= n_d;
        r_w      <= n_w;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.joined        <= r_joined;
            r_out.total_weight  <= r_total;
            r_out.tree_edges    <= r_cnt;
            r_out.tree_complete <= (NCW'(r_cnt) >= last_edge);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `KUFE_ASSERT_IMPLY(a_write_phase, ram_we, (r_state == ST_CLEAR) || (r_state == ST_FIND_D))
    `KUFE_ASSERT_IMPLY(a_no_self_link, ram_we && (r_state == ST_FIND_D), ram_wdata != ram_waddr)
    `KUFE_ASSERT_IMPLY(a_join_counted, o_out_valid && o_out_data.joined, o_out_data.tree_edges != '0)
    `KUFE_ASSERT_IMPLY(a_empty_tree_zero, o_out_valid && (o_out_data.tree_edges == '0), o_out_data.total_weight == '0)

endmodule

`default_nettype wire
